@@ sv/stffi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package stffi_pkg;

	// table geometry
	localparam int NUM_SLOTS   = 64;
	localparam int ENTRY_WIDTH = 64;
	localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int COUNT_W     = $clog2(NUM_SLOTS + 1);
	localparam int OWNER_W     = 8;
	localparam int WORD_W      = ENTRY_WIDTH + OWNER_W;

	// fixed field widths of the channels
	localparam int CMD_W       = 2;
	localparam int DATA_W      = 64;
	localparam int IDX_W       = 6;
	localparam int CNT_OUT_W   = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_code_t;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [DATA_W-1:0]  entry_data;
		logic [OWNER_W-1:0] owner_node;
		logic [IDX_W-1:0]   slot_index;
	} item_t;

	// decisions of the control logic for one command
	typedef struct packed {
		logic                 wr_en;
		logic [SLOT_W-1:0]    wr_addr;
		logic                 rd_en;
		logic [SLOT_W-1:0]    rd_addr;
		logic                 ok;
		logic [IDX_W-1:0]     slot_used;
		logic                 read_hit;
		logic [CNT_OUT_W-1:0] entry_count;
	} ctrl_t;

endpackage

`default_nettype wire

@@ sv/stffi_cmd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface stffi_cmd_if;
	import stffi_pkg::*;

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [DATA_W-1:0]  entry_data;
	logic [OWNER_W-1:0] owner_node;
	logic [IDX_W-1:0]   slot_index;

	modport source (output valid, command, entry_data, owner_node, slot_index, input ready);
	modport sink   (input valid, command, entry_data, owner_node, slot_index, output ready);
endinterface

`default_nettype wire

@@ sv/stffi_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface stffi_rsp_if;
	import stffi_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 ok;
	logic [IDX_W-1:0]     slot_used;
	logic [DATA_W-1:0]    read_data;
	logic [OWNER_W-1:0]   read_owner;
	logic                 read_valid;
	logic [CNT_OUT_W-1:0] entry_count;

	modport source (output valid, ok, slot_used, read_data, read_owner, read_valid,
		entry_count, input ready);
	modport sink   (input valid, ok, slot_used, read_data, read_owner, read_valid,
		entry_count, output ready);
endinterface

`default_nettype wire

@@ sv/stffi_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stffi_mem
	import stffi_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [SLOT_W-1:0] wr_addr,
	input  wire logic [WORD_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [SLOT_W-1:0] rd_addr,
	output logic      [WORD_W-1:0] rd_data_q
);

	logic [WORD_W-1:0] mem_q [NUM_SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ sv/stffi_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stffi_ctrl
	import stffi_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire item_t item,
	input  wire logic  fire,
	output ctrl_t      ctrl
);

	logic [NUM_SLOTS-1:0] valid_q, valid_d;
	logic [COUNT_W-1:0]   count_q, count_d;
	logic                 free_found;
	logic [SLOT_W-1:0]    free_idx;
	logic                 in_range;
	logic [SLOT_W-1:0]    addr;
	logic                 slot_hit;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		in_range = int'(item.slot_index) < NUM_SLOTS;
		addr     = SLOT_W'(item.slot_index);
		slot_hit = in_range && valid_q[addr];

		valid_d          = valid_q;
		count_d          = count_q;
		ctrl.wr_en       = 1'b0;
		ctrl.wr_addr     = free_idx;
		ctrl.rd_en       = 1'b0;
		ctrl.rd_addr     = addr;
		ctrl.ok          = 1'b0;
		ctrl.slot_used   = item.slot_index;
		ctrl.read_hit    = 1'b0;

		unique case (cmd_code_t'(item.command))
			CMD_INSERT: begin
				ctrl.slot_used = '0;
				if (free_found) begin
					valid_d[free_idx] = 1'b1;
					count_d           = count_q + COUNT_W'(1);
					ctrl.wr_en        = 1'b1;
					ctrl.ok           = 1'b1;
					ctrl.slot_used    = IDX_W'(free_idx);
				end
			end
			CMD_DELETE: begin
				if (slot_hit && count_q != '0) begin
					valid_d[addr] = 1'b0;
					count_d       = count_q - COUNT_W'(1);
					ctrl.ok       = 1'b1;
				end
			end
			CMD_READ: begin
				ctrl.ok       = 1'b1;
				ctrl.rd_en    = in_range;
				ctrl.read_hit = slot_hit;
			end
			CMD_CLEAR: begin
				valid_d        = '0;
				count_d        = '0;
				ctrl.ok        = 1'b1;
				ctrl.slot_used = '0;
			end
			default: begin
			end
		endcase

		ctrl.entry_count = CNT_OUT_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (fire) begin
			valid_q <= valid_d;
			count_q <= count_d;
		end
	end

endmodule

`default_nettype wire

@@ sv/slot_table_first_free_insert_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel  role    payload
// -------  ------  ------------------------------------------------------------
// cmd      sink    command, entry_data, owner_node, slot_index
// rsp      source  ok, slot_used, read_data, read_owner, read_valid, entry_count
//
// one command per cycle sustained while rsp is ready; a result passes through the input
// register, then decision logic and table access into the output register
// the free-slot search is a priority encoder over the valid bitmap in the same cycle
// reset clears the valid bitmap, the count and the pipeline valid flags only
// a stalled rsp holds the output register; cmd keeps taking items while the
//   input register can move forward or is empty

module slot_table_first_free_insert_unit
	import stffi_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	stffi_cmd_if.sink   cmd,
	stffi_rsp_if.source rsp
);

	// input register
	logic  s1_valid_q;
	item_t item_s1;
	logic  adv_s1;

	// output register
	logic                 s2_valid_q;
	logic                 ok_s2;
	logic [IDX_W-1:0]     used_s2;
	logic                 hit_s2;
	logic [CNT_OUT_W-1:0] count_s2;

	ctrl_t             ctrl;
	logic [WORD_W-1:0] rd_word;

	// the input stage moves when the output register is empty or being drained
	assign adv_s1    = s1_valid_q && (!s2_valid_q || rsp.ready);
	assign cmd.ready = !s1_valid_q || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (cmd.ready) begin
			s1_valid_q <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.command    <= cmd.command;
			item_s1.entry_data <= cmd.entry_data;
			item_s1.owner_node <= cmd.owner_node;
			item_s1.slot_index <= cmd.slot_index;
		end
	end

	// bitmap, count and per-command decisions; state commits on advance only
	stffi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.fire   (adv_s1),
		.ctrl   (ctrl)
	);

	// record store, owner id above the entry word; read data lands with the result
	stffi_mem u_mem (
		.clk       (clk),
		.wr_en     (adv_s1 && ctrl.wr_en),
		.wr_addr   (ctrl.wr_addr),
		.wr_data   ({item_s1.owner_node, ENTRY_WIDTH'(item_s1.entry_data)}),
		.rd_en     (adv_s1 && ctrl.rd_en),
		.rd_addr   (ctrl.rd_addr),
		.rd_data_q (rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (adv_s1) begin
			s2_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ok_s2    <= ctrl.ok;
			used_s2  <= ctrl.slot_used;
			hit_s2   <= ctrl.read_hit;
			count_s2 <= ctrl.entry_count;
		end
	end

	// read fields are zero unless a read found a valid slot
	assign rsp.valid       = s2_valid_q;
	assign rsp.ok          = ok_s2;
	assign rsp.slot_used   = used_s2;
	assign rsp.read_valid  = hit_s2;
	assign rsp.read_data   = hit_s2 ? DATA_W'(rd_word[ENTRY_WIDTH-1:0]) : '0;
	assign rsp.read_owner  = hit_s2 ? rd_word[WORD_W-1:ENTRY_WIDTH] : '0;
	assign rsp.entry_count = count_s2;

endmodule

`default_nettype wire
